// ----- hw/rtl/fct_pkg.sv -----
// Shared constants, types and helpers for the frustum cull tester.
// No dependencies; imported by fct_plane_unit and frustum_cull_tester.
`timescale 1ns / 1ps

package fct_pkg;

    localparam int COORD_BITS  = 16;
    localparam int NUM_PLANES  = 6;
    localparam int FRAC_SHIFT  = 14;
    localparam int EXTENT_BITS = 15;
    localparam int COEF_W      = 16;
    localparam int PLANE_W     = 4 * COEF_W;
    localparam int CFG_IDX_W   = 3;

    // a*x product, |a|+|b|+|c| and extent*(|a|+|b|+|c|)
    localparam int PROD_W  = COORD_BITS + COEF_W;
    localparam int ABS_W   = COEF_W + 2;
    localparam int EPROD_W = EXTENT_BITS + ABS_W;
    localparam int DTERM_W = COEF_W + FRAC_SHIFT;
    localparam int ETERM_W = EXTENT_BITS + FRAC_SHIFT;
    localparam int BASE_W  = (PROD_W > EPROD_W) ? PROD_W : EPROD_W;
    // headroom for three products, the offset term and one correction
    localparam int SUM_W   = BASE_W + 3;

    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_CUBE   = 2'd2;
    localparam logic [1:0] OP_VERTEX = 2'd3;

    typedef struct packed {
        logic pos;       // centre distance strictly positive
        logic sph_cull;  // centre distance below minus the radius
        logic cube_pos;  // nearest-to-inside corner strictly positive
    } t_plane_flags;

    function automatic logic [COEF_W-1:0] abs_coef(input logic [COEF_W-1:0] c);
        logic [COEF_W:0] t;
        t = {c[COEF_W-1], c};
        if (c[COEF_W-1]) begin
            t = '0 - t;
        end
        return t[COEF_W-1:0];
    endfunction

    function automatic logic [ABS_W-1:0] abs_sum(input logic [PLANE_W-1:0] p);
        logic [ABS_W-1:0] s;
        s = ABS_W'(abs_coef(p[COEF_W-1:0]))
          + ABS_W'(abs_coef(p[2*COEF_W-1:COEF_W]))
          + ABS_W'(abs_coef(p[3*COEF_W-1:2*COEF_W]));
        return s;
    endfunction

endpackage

// ----- hw/rtl/fct_plane_unit.sv -----
// One frustum plane: registered products, then distance sums and sign tests.
// Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_plane_unit
    import fct_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic        [PLANE_W-1:0]     i_plane,
    input  logic        [ABS_W-1:0]       i_abs_sum,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic signed [COORD_BITS-1:0]  i_pos_z,
    input  logic        [EXTENT_BITS-1:0] i_extent,
    input  logic        [EXTENT_BITS-1:0] i_extent_b,
    output t_plane_flags                  o_flags
);

    logic signed [COEF_W-1:0]  w_a, w_b, w_c, w_d;
    logic signed [PROD_W-1:0]  r_px, r_py, r_pz;
    logic        [EPROD_W-1:0] r_pe;
    logic signed [SUM_W-1:0]   w_dist, w_sph, w_cube;

    assign w_a = i_plane[COEF_W-1:0];
    assign w_b = i_plane[2*COEF_W-1:COEF_W];
    assign w_c = i_plane[3*COEF_W-1:2*COEF_W];
    assign w_d = i_plane[4*COEF_W-1:3*COEF_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= w_a * i_pos_x;
            r_py <= w_b * i_pos_y;
            r_pz <= w_c * i_pos_z;
            r_pe <= EPROD_W'(i_extent) * EPROD_W'(i_abs_sum);
        end
    end

    // distance scaled by 2^14; user must keep offset stable while items in flight
    always_comb begin
        w_dist = {{(SUM_W-PROD_W){r_px[PROD_W-1]}}, r_px}
               + {{(SUM_W-PROD_W){r_py[PROD_W-1]}}, r_py}
               + {{(SUM_W-PROD_W){r_pz[PROD_W-1]}}, r_pz}
               + {{(SUM_W-DTERM_W){w_d[COEF_W-1]}}, w_d, {FRAC_SHIFT{1'b0}}};
        w_sph  = w_dist + {{(SUM_W-ETERM_W){1'b0}}, i_extent_b, {FRAC_SHIFT{1'b0}}};
        // best corner of the cube moves each axis by extent toward the plane normal
        w_cube = w_dist + {{(SUM_W-EPROD_W){1'b0}}, r_pe};
        o_flags.pos      = !w_dist[SUM_W-1] && (|w_dist);
        o_flags.sph_cull = w_sph[SUM_W-1];
        o_flags.cube_pos = !w_cube[SUM_W-1] && (|w_cube);
    end

endmodule

// ----- hw/rtl/frustum_cull_tester.sv -----
// Top level of the six-plane frustum cull tester.
// Depends on fct_pkg and fct_plane_unit.
`timescale 1ns / 1ps

// Takes one primitive or polygon vertex per cycle unless i_ready holds the
// output, as each of the six planes has its own multipliers, and answers with
// a visible flag: the input register takes the item, then the plane product
// register and the result register follow. Points, spheres and cubes give one
// result each; polygon vertices give a result only on the vertex marked last.
// Planes are loaded through the configuration port (index 0 to 5, a in bits
// 15:0, b 31:16, c 47:32, d 63:48) while the block is idle; the user must keep
// to this, as the block does not enforce it.
module frustum_cull_tester
    import fct_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [PLANE_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic        [1:0]             i_op,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic signed [COORD_BITS-1:0]  i_pos_z,
    input  logic        [EXTENT_BITS-1:0] i_extent,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_visible
);

    logic [PLANE_W-1:0]   r_plane [NUM_PLANES];
    logic [ABS_W-1:0]     r_abs   [NUM_PLANES];

    logic                          r_a_valid;
    logic [1:0]                    r_a_op;
    logic signed [COORD_BITS-1:0]  r_a_x, r_a_y, r_a_z;
    logic [EXTENT_BITS-1:0]        r_a_ext;
    logic                          r_a_last;

    logic                   r_b_valid;
    logic [1:0]             r_b_op;
    logic [EXTENT_BITS-1:0] r_b_ext;
    logic                   r_b_last;

    logic [NUM_PLANES-1:0]  r_mask, n_mask;
    logic                   r_out_valid;
    logic                   r_out_vis, n_vis;

    t_plane_flags           w_flags [NUM_PLANES];
    logic [NUM_PLANES-1:0]  w_pos, w_sph, w_cube;
    logic                   w_has_result;
    logic                   w_out_free, w_b_adv, w_b_free, w_a_adv, w_a_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_PLANES; f++) begin
                r_plane[f] <= '0;
                r_abs[f]   <= '0;
            end
        end else if (i_cfg_valid) begin
            // indexes beyond the plane list drop the write
            for (int f = 0; f < NUM_PLANES; f++) begin
                if (i_cfg_index == CFG_IDX_W'(f)) begin
                    r_plane[f] <= i_cfg_data;
                    r_abs[f]   <= abs_sum(i_cfg_data);
                end
            end
        end
    end

    // stall chain: a stage advances when the next one is free or draining, or when its vertex gives no result
    assign w_has_result = (r_b_op != OP_VERTEX) || r_b_last;
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_b_adv      = r_b_valid && (w_out_free || !w_has_result);
    assign w_b_free     = !r_b_valid || w_b_adv;
    assign w_a_adv      = r_a_valid && w_b_free;
    assign w_a_free     = !r_a_valid || w_a_adv;
    assign o_ready      = w_a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_a_free) begin
            r_a_op   <= i_op;
            r_a_x    <= i_pos_x;
            r_a_y    <= i_pos_y;
            r_a_z    <= i_pos_z;
            r_a_ext  <= i_extent;
            r_a_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_b_op   <= r_a_op;
            r_b_ext  <= r_a_ext;
            r_b_last <= r_a_last;
        end
    end

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        fct_plane_unit u_plane (
            .i_clk      (i_clk),
            .i_en       (w_a_adv),
            .i_plane    (r_plane[g]),
            .i_abs_sum  (r_abs[g]),
            .i_pos_x    (r_a_x),
            .i_pos_y    (r_a_y),
            .i_pos_z    (r_a_z),
            .i_extent   (r_a_ext),
            .i_extent_b (r_b_ext),
            .o_flags    (w_flags[g])
        );
        assign w_pos[g]  = w_flags[g].pos;
        assign w_sph[g]  = w_flags[g].sph_cull;
        assign w_cube[g] = w_flags[g].cube_pos;
    end

    always_comb begin
        n_mask = r_mask;
        case (r_b_op)
            OP_POINT:  n_vis = &w_pos;
            OP_SPHERE: n_vis = ~|w_sph;
            OP_CUBE:   n_vis = &w_cube;
            OP_VERTEX: begin
                n_mask = r_mask | w_pos;
                n_vis  = &n_mask;
            end
            default:   n_vis = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (w_b_adv && (r_b_op == OP_VERTEX)) begin
            // clear on the closing vertex, accumulate otherwise
            r_mask <= r_b_last ? '0 : n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_b_adv && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv && w_has_result) begin
            r_out_vis <= n_vis;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_visible = r_out_vis;

endmodule
